>>> rtl/codel_pkg.sv
package codel_pkg;

  localparam int TIME_BITS    = 48;
  localparam int COUNT_BITS   = 16;
  localparam int CFG_BITS     = 24;
  localparam int BYTES_BITS   = 16;
  localparam int BACKLOG_BITS = 32;
  localparam int SQ_BITS      = 2 * CFG_BITS;
  localparam int ROOT_BITS    = SQ_BITS / 2;
  localparam int STEP_BITS    = $clog2(SQ_BITS + 1);
  localparam int REENTRY_SHIFT = 4;

  localparam logic [CFG_BITS-1:0]   TARGET_RESET   = CFG_BITS'(5000);
  localparam logic [CFG_BITS-1:0]   INTERVAL_RESET = CFG_BITS'(100000);
  localparam logic [BYTES_BITS-1:0] MAXPKT_RESET   = BYTES_BITS'(256);

  localparam logic REG_TARGET   = 1'b0;
  localparam logic REG_INTERVAL = 1'b1;

  localparam logic [1:0] ACT_DELIVER = 2'd0;
  localparam logic [1:0] ACT_DROP    = 2'd1;
  localparam logic [1:0] ACT_EMPTY   = 2'd2;

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_LOOP  = 2'd1;
  localparam logic [1:0] PH_ENTER = 2'd2;

  typedef struct packed {
    logic                  start;
    logic [CFG_BITS-1:0]   interval;
    logic [COUNT_BITS-1:0] count;
  } law_req_t;

  typedef struct packed {
    logic                 done;
    logic [ROOT_BITS-1:0] q;
  } law_rsp_t;

endpackage

>>> rtl/codel_law.sv
module codel_law import codel_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  law_req_t req,
  output law_rsp_t rsp
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_DIV  = 4'b0100,
    L_SQRT = 4'b1000
  } law_state_t;

  law_state_t             state;
  logic [CFG_BITS-1:0]    ival;
  logic [COUNT_BITS-1:0]  divisor;
  logic [SQ_BITS-1:0]     work;
  logic [COUNT_BITS-1:0]  rem_div;
  logic [ROOT_BITS-1:0]   root;
  logic [ROOT_BITS+1:0]   rem_sq;
  logic [STEP_BITS-1:0]   steps;
  logic                   done;

  logic [COUNT_BITS:0]    div_trial;
  logic [COUNT_BITS:0]    div_diff;
  logic                   div_ge;
  logic [ROOT_BITS+2:0]   sq_shift;
  logic [ROOT_BITS+2:0]   sq_trial;
  logic [ROOT_BITS+2:0]   sq_diff;
  logic                   sq_ge;

  // Restoring divide: one quotient bit per cycle.
  assign div_trial = {rem_div, work[SQ_BITS-1]};
  assign div_ge    = div_trial >= {1'b0, divisor};
  assign div_diff  = div_trial - {1'b0, divisor};

  // Digit-by-digit square root: one root bit per cycle.
  assign sq_shift = {rem_sq[ROOT_BITS:0], work[SQ_BITS-1 -: 2]};
  assign sq_trial = {1'b0, root, 2'b01};
  assign sq_ge    = sq_shift >= sq_trial;
  assign sq_diff  = sq_shift - sq_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (req.start) begin
            ival    <= req.interval;
            divisor <= (req.count == '0) ? COUNT_BITS'(1) : req.count;
            state   <= L_MUL;
          end
        end
        L_MUL: begin
          work    <= {{(SQ_BITS-CFG_BITS){1'b0}}, ival} * {{(SQ_BITS-CFG_BITS){1'b0}}, ival};
          rem_div <= '0;
          steps   <= STEP_BITS'(SQ_BITS - 1);
          state   <= L_DIV;
        end
        L_DIV: begin
          work    <= {work[SQ_BITS-2:0], div_ge};
          rem_div <= div_ge ? div_diff[COUNT_BITS-1:0] : div_trial[COUNT_BITS-1:0];
          steps   <= steps - STEP_BITS'(1);
          if (steps == '0) begin
            root   <= '0;
            rem_sq <= '0;
            steps  <= STEP_BITS'(ROOT_BITS - 1);
            state  <= L_SQRT;
          end
        end
        L_SQRT: begin
          work   <= {work[SQ_BITS-3:0], 2'b00};
          root   <= {root[ROOT_BITS-2:0], sq_ge};
          rem_sq <= sq_ge ? sq_diff[ROOT_BITS+1:0] : sq_shift[ROOT_BITS+1:0];
          steps  <= steps - STEP_BITS'(1);
          if (steps == '0) begin
            done  <= 1'b1;
            state <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.q    = root;

endmodule

>>> rtl/codel_dequeue_drop_decision_core.sv
// CoDel dequeue drop decision. Each input beat is one head-of-queue packet
// (or an empty mark); each gives exactly one result beat: deliver, drop or
// empty, with the dropping flag and drop count after it. Time is in integer
// ticks; time sums saturate, and the drop count saturates at its maximum.
// The block handles one packet at a time and is not ready while it works.
// A packet with no control-law update runs the sample, compare, decide and
// done states. A packet that updates the next drop time (entering the
// dropping state, or a drop inside the dropping loop) also passes the law
// and post states. The control law floor(interval / sqrt(count)) runs in
// a shared iterative unit: one 24x24 square, a 48-step restoring divide by
// the count and a 24-step square root. The result sits in an output
// register, so the next packet may be accepted before the result is taken.
// Configuration: index 0 target_ticks, index 1 interval_ticks; write only
// while the block is idle.
module codel_dequeue_drop_decision_core import codel_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic                    cfg_index,
  input  logic [CFG_BITS-1:0]     cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    queue_empty,
  input  logic [TIME_BITS-1:0]    now_ticks,
  input  logic [TIME_BITS-1:0]    enqueue_ticks,
  input  logic [BYTES_BITS-1:0]   packet_bytes,
  input  logic [BACKLOG_BITS-1:0] backlog_bytes,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              action,
  output logic                    dropping_state,
  output logic [COUNT_BITS-1:0]   drop_count
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SAMPLE = 7'b0000010,
    S_CMP    = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_LAW    = 7'b0010000,
    S_POST   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  state_t state;

  // configuration
  logic [CFG_BITS-1:0] target;
  logic [CFG_BITS-1:0] interval;

  // captured beat
  logic                    cap_empty;
  logic [TIME_BITS-1:0]    cap_now;
  logic [TIME_BITS-1:0]    cap_enq;
  logic [BYTES_BITS-1:0]   cap_bytes;
  logic [BACKLOG_BITS-1:0] cap_backlog;

  // control state
  logic                  in_dropping;
  logic [TIME_BITS-1:0]  first_above;
  logic [TIME_BITS-1:0]  next_drop;
  logic [COUNT_BITS-1:0] drop_counter;
  logic [BYTES_BITS-1:0] largest;
  logic [1:0]            call_phase;

  // sequencer scratch
  logic [TIME_BITS:0]    soj_diff;
  logic [TIME_BITS:0]    ndt_diff;
  logic                  backlog_gt;
  logic                  below;
  logic                  ge_fat;
  logic                  recent;
  logic [TIME_BITS-1:0]  fat_sum;
  logic [TIME_BITS-1:0]  law_base;
  logic                  law_loop;
  logic                  law_start;
  logic [COUNT_BITS-1:0] law_count;
  logic [1:0]            act;

  logic [BYTES_BITS-1:0] largest_next;
  logic [1:0]            phase;
  logic                  ok;
  logic [COUNT_BITS-1:0] count_inc;
  logic [COUNT_BITS-1:0] count_enter;
  logic [TIME_BITS-1:0]  interval_ext;
  logic [TIME_BITS-1:0]  reentry_span;

  law_req_t law_req;
  law_rsp_t law_rsp;

  assign in_ready     = (state == S_IDLE);
  assign largest_next = (largest < cap_bytes) ? cap_bytes : largest;
  assign phase        = (call_phase == PH_LOOP || call_phase == PH_ENTER) ? call_phase
                                                                          : PH_FIRST;
  assign ok           = !below && (first_above != '0) && ge_fat;
  assign count_inc    = (drop_counter == {COUNT_BITS{1'b1}}) ? drop_counter
                                                             : drop_counter + COUNT_BITS'(1);
  assign count_enter  = (drop_counter > COUNT_BITS'(1) && recent)
                        ? drop_counter - COUNT_BITS'(1) : COUNT_BITS'(1);
  assign interval_ext = {{(TIME_BITS-CFG_BITS){1'b0}}, interval};
  assign reentry_span = {{(TIME_BITS-CFG_BITS-REENTRY_SHIFT){1'b0}}, interval,
                         {REENTRY_SHIFT{1'b0}}};

  assign law_req.start    = law_start;
  assign law_req.interval = interval;
  assign law_req.count    = law_count;

  codel_law u_law (
    .clk (clk),
    .rst (rst),
    .req (law_req),
    .rsp (law_rsp)
  );

  // Configuration registers: written any time; read while a beat is in work.
  always_ff @(posedge clk) begin
    if (rst) begin
      target   <= TARGET_RESET;
      interval <= INTERVAL_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TARGET:   target   <= cfg_data;
        REG_INTERVAL: interval <= cfg_data;
        default:      target   <= target;
      endcase
    end
  end

  // Capture the input beat.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cap_empty   <= queue_empty;
      cap_now     <= now_ticks;
      cap_enq     <= enqueue_ticks;
      cap_bytes   <= packet_bytes;
      cap_backlog <= backlog_bytes;
    end
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      in_dropping  <= 1'b0;
      first_above  <= '0;
      next_drop    <= '0;
      drop_counter <= '0;
      largest      <= MAXPKT_RESET;
      call_phase   <= PH_FIRST;
      law_start    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      law_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_SAMPLE;
          end
        end
        S_SAMPLE: begin
          // Track the largest packet and take both time differences.
          if (!cap_empty) begin
            largest <= largest_next;
          end
          backlog_gt <= cap_backlog > {{(BACKLOG_BITS-BYTES_BITS){1'b0}}, largest_next};
          soj_diff   <= {1'b0, cap_now} - {1'b0, cap_enq};
          ndt_diff   <= {1'b0, cap_now} - {1'b0, next_drop};
          state      <= S_CMP;
        end
        S_CMP: begin
          // A negative sojourn (enqueue after now) counts as below target.
          below   <= soj_diff[TIME_BITS]
                     || (soj_diff[TIME_BITS-1:0] < {{(TIME_BITS-CFG_BITS){1'b0}}, target})
                     || !backlog_gt;
          ge_fat  <= cap_now >= first_above;
          recent  <= ndt_diff[TIME_BITS] || (ndt_diff[TIME_BITS-1:0] < reentry_span);
          fat_sum <= sat_add(cap_now, interval_ext);
          state   <= S_CMP == state ? S_DECIDE : S_IDLE;
        end
        S_DECIDE: begin
          act   <= ACT_DELIVER;
          state <= S_DONE;
          if (cap_empty) begin
            // Empty queue: end the call, and leave dropping inside the loop.
            first_above <= '0;
            if (phase == PH_LOOP) begin
              in_dropping <= 1'b0;
            end
            act        <= ACT_EMPTY;
            call_phase <= PH_FIRST;
          end else begin
            if (below) begin
              first_above <= '0;
            end else if (first_above == '0) begin
              first_above <= fat_sum;
            end
            call_phase <= PH_FIRST;
            if (phase == PH_LOOP) begin
              if (!ok) begin
                in_dropping <= 1'b0;
              end else begin
                // Advance next drop time from itself, then retest.
                law_start <= 1'b1;
                law_count <= drop_counter;
                law_base  <= next_drop;
                law_loop  <= 1'b1;
                state     <= S_LAW;
              end
            end else if (phase == PH_ENTER) begin
              call_phase <= PH_FIRST;
            end else if (in_dropping) begin
              if (!ok) begin
                in_dropping <= 1'b0;
              end else if (!ndt_diff[TIME_BITS]) begin
                drop_counter <= count_inc;
                act          <= ACT_DROP;
                call_phase   <= PH_LOOP;
              end
            end else if (ok) begin
              // Enter dropping; resume near the old count if it was recent.
              in_dropping  <= 1'b1;
              drop_counter <= count_enter;
              law_start    <= 1'b1;
              law_count    <= count_enter;
              law_base     <= cap_now;
              law_loop     <= 1'b0;
              act          <= ACT_DROP;
              call_phase   <= PH_ENTER;
              state        <= S_LAW;
            end
          end
        end
        S_LAW: begin
          if (law_rsp.done) begin
            next_drop <= sat_add(law_base, {{(TIME_BITS-ROOT_BITS){1'b0}}, law_rsp.q});
            state     <= S_POST;
          end
        end
        S_POST: begin
          if (law_loop && cap_now >= next_drop) begin
            drop_counter <= count_inc;
            act          <= ACT_DROP;
            call_phase   <= PH_LOOP;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          // Hold until the output register is free, then load the result.
          if (!out_valid || out_ready) begin
            action         <= act;
            dropping_state <= in_dropping;
            drop_count     <= drop_counter;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("sequencer stayed ready after accepting a beat");

  a_law_done_in_law: assert property (@(posedge clk) disable iff (rst)
    law_rsp.done |-> (state == S_LAW))
    else $error("control-law result arrived outside the law wait");

  a_drop_while_dropping: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action == ACT_DROP) |-> dropping_state)
    else $error("drop reported outside the dropping state");
`endif

endmodule
